// ===== rtl/single_wire_humidity_sensor_reader_top_defines.svh =====
// Assertion macros for the single-wire sensor reader.
// Both macros use the enclosing module's clock and reset.
`ifndef SINGLE_WIRE_HUMIDITY_SENSOR_READER_TOP_DEFINES_SVH
`define SINGLE_WIRE_HUMIDITY_SENSOR_READER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define SWHR_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("swhr assertion failed");

// Next-cycle implication
`define SWHR_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("swhr assertion failed");

`else

`define SWHR_ASSERT_SAME(lbl, ante, cons)
`define SWHR_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/swhr_pkg.sv =====
package swhr_pkg;

   localparam int unsigned FRAME_BYTES   = 5;
   localparam int unsigned FRAME_BITS    = 8 * FRAME_BYTES;
   localparam int unsigned BIT_IDX_W     = $clog2(FRAME_BITS);
   localparam int unsigned COUNTER_WIDTH = 16;
   localparam logic [COUNTER_WIDTH-1:0] CNT_MAX = {COUNTER_WIDTH{1'b1}};

   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned CSR_DATA_W = 32;

   // Register reset values
   localparam logic [15:0] START_LOW_RST     = 16'd18000;
   localparam logic [9:0]  PRESENCE_DLY_RST  = 10'd105;
   localparam logic [9:0]  DATA_WAIT_RST     = 10'd80;
   localparam logic [7:0]  SAMPLE_DLY_RST    = 8'd30;
   localparam logic [15:0] BIT_TIMEOUT_RST   = 16'd1000;

   typedef enum logic [2:0] {
      REG_START_LOW    = 3'd0,
      REG_PRESENCE_DLY = 3'd1,
      REG_DATA_WAIT    = 3'd2,
      REG_SAMPLE_DLY   = 3'd3,
      REG_BIT_TIMEOUT  = 3'd4
   } reg_idx_type;

   typedef enum logic [2:0] {
      PH_IDLE      = 3'd0,
      PH_START_LOW = 3'd1,
      PH_PRESENCE  = 3'd2,
      PH_DATA_WAIT = 3'd3,
      PH_WAIT_RISE = 3'd4,
      PH_SAMPLE    = 3'd5,
      PH_WAIT_FALL = 3'd6
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK          = 2'd0,
      ST_CHECKSUM    = 2'd1,
      ST_NO_PRESENCE = 2'd2,
      ST_TIMEOUT     = 2'd3
   } status_type;

   typedef struct packed {
      logic [15:0] start_low_ticks;
      logic [9:0]  presence_delay_ticks;
      logic [9:0]  data_wait_ticks;
      logic [7:0]  sample_delay_ticks;
      logic [15:0] bit_timeout_ticks;
   } cfg_type;

   typedef struct packed {
      logic       start_request;
      logic       line_level;
      logic [7:0] light_sample;
   } req_type;

   typedef struct packed {
      logic       drive_low;
      logic       busy_res;
      logic       done_res;
      logic [1:0] status;
      logic [7:0] temperature;
      logic [7:0] humidity;
      logic [7:0] light_level;
      logic [7:0] payload_sum;
   } rsp_type;

   // Limit a register value to the counter range
   function automatic logic [COUNTER_WIDTH-1:0] clamp_limit(input logic [15:0] v);
      logic [31:0] wide;
      wide = 32'(v);
      if (wide > 32'(CNT_MAX)) begin
         return CNT_MAX;
      end
      return wide[COUNTER_WIDTH-1:0];
   endfunction

   // Byte k of the frame, byte 0 received first; absent bytes read zero
   function automatic logic [7:0] frame_byte(input logic [FRAME_BITS-1:0] f,
                                             input int unsigned k);
      if (k >= FRAME_BYTES) begin
         return 8'd0;
      end
      return f[8 * (FRAME_BYTES - 1 - k) +: 8];
   endfunction

endpackage

// ===== rtl/single_wire_humidity_sensor_reader_top.sv =====
// A req word is held in the input register, its result word in the result register
// on rsp until taken at an edge with rsp_ready high. Throughput: one word per cycle
// while rsp_ready is high; each word is one tick of the sensor line sequencer.
// An input register and a result register part the two channels, so while a finished
// result waits, req_ready stays high only until the input register holds a word.
// Reset (synchronous): sequencer to idle, both channels empty, registers to defaults.
module single_wire_humidity_sensor_reader_top
   import swhr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type cfg;
   logic    in_valid_ff;
   logic    in_valid_in;
   req_type in_word_ff;
   logic    out_valid_ff;
   logic    out_valid_in;
   rsp_type out_word_ff;
   rsp_type step_word;
   logic    step_en;
   logic    req_fire;

   swhr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   swhr_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .req     (in_word_ff),
      .cfg     (cfg),
      .rsp     (step_word)
   );

   // Advance when the result register is free or being drained
   assign step_en   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step_en;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_word_ff;

   always_comb begin
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (step_en) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_comb begin
      if (step_en) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Hold payloads until replaced
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_word_ff <= req_data;
      end
      if (step_en) begin
         out_word_ff <= step_word;
      end
   end

endmodule

// ===== rtl/swhr_csr.sv =====
module swhr_csr
   import swhr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   reg_idx_type reg_idx;
   logic        wr_en;

   assign reg_idx    = reg_idx_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   // Write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_START_LOW:    cfg_in.start_low_ticks      = csr_pwdata[15:0];
            REG_PRESENCE_DLY: cfg_in.presence_delay_ticks = csr_pwdata[9:0];
            REG_DATA_WAIT:    cfg_in.data_wait_ticks      = csr_pwdata[9:0];
            REG_SAMPLE_DLY:   cfg_in.sample_delay_ticks   = csr_pwdata[7:0];
            REG_BIT_TIMEOUT:  cfg_in.bit_timeout_ticks    = csr_pwdata[15:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   // Read mux
   always_comb begin
      case (reg_idx)
         REG_START_LOW:    csr_prdata = 32'(cfg_ff.start_low_ticks);
         REG_PRESENCE_DLY: csr_prdata = 32'(cfg_ff.presence_delay_ticks);
         REG_DATA_WAIT:    csr_prdata = 32'(cfg_ff.data_wait_ticks);
         REG_SAMPLE_DLY:   csr_prdata = 32'(cfg_ff.sample_delay_ticks);
         REG_BIT_TIMEOUT:  csr_prdata = 32'(cfg_ff.bit_timeout_ticks);
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_low_ticks      <= START_LOW_RST;
         cfg_ff.presence_delay_ticks <= PRESENCE_DLY_RST;
         cfg_ff.data_wait_ticks      <= DATA_WAIT_RST;
         cfg_ff.sample_delay_ticks   <= SAMPLE_DLY_RST;
         cfg_ff.bit_timeout_ticks    <= BIT_TIMEOUT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/swhr_core.sv =====
`include "single_wire_humidity_sensor_reader_top_defines.svh"

module swhr_core
   import swhr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    step_en,
   input  req_type req,
   input  cfg_type cfg,
   output rsp_type rsp
);

   phase_type              phase_ff;
   phase_type              phase_in;
   logic [COUNTER_WIDTH-1:0] tick_cnt_ff;
   logic [COUNTER_WIDTH-1:0] tick_cnt_in;
   logic [BIT_IDX_W-1:0]   bit_idx_ff;
   logic [BIT_IDX_W-1:0]   bit_idx_in;
   logic [FRAME_BITS-1:0]  frame_ff;
   logic [FRAME_BITS-1:0]  frame_in;
   logic [7:0]             light_ff;
   logic [7:0]             light_in;

   logic [COUNTER_WIDTH-1:0] cnt_step;
   logic [COUNTER_WIDTH-1:0] limit;
   logic                   reached;
   logic                   last_bit;
   logic                   end_no_presence;
   logic                   end_timeout;
   logic                   end_frame;
   logic                   done;
   logic [7:0]             check_acc;
   logic                   check_ok;
   status_type             status;

   // Saturating tick counter step and the limit of the current phase
   assign cnt_step = (tick_cnt_ff == CNT_MAX) ? tick_cnt_ff : tick_cnt_ff + 1'b1;

   always_comb begin
      case (phase_ff)
         PH_START_LOW: limit = clamp_limit(cfg.start_low_ticks);
         PH_PRESENCE:  limit = clamp_limit(16'(cfg.presence_delay_ticks));
         PH_DATA_WAIT: limit = clamp_limit(16'(cfg.data_wait_ticks));
         PH_SAMPLE:    limit = clamp_limit(16'(cfg.sample_delay_ticks));
         default:      limit = clamp_limit(cfg.bit_timeout_ticks);
      endcase
   end

   assign reached  = cnt_step >= limit;
   assign last_bit = (32'(bit_idx_ff) + 32'd1) >= 32'(FRAME_BITS);

   // Ways a measurement ends
   assign end_no_presence = (phase_ff == PH_PRESENCE) && reached && !req.line_level;
   assign end_timeout     = ((phase_ff == PH_WAIT_RISE) && !req.line_level && reached) ||
                            ((phase_ff == PH_WAIT_FALL) && req.line_level && reached);
   assign end_frame       = (phase_ff == PH_WAIT_FALL) && !req.line_level && last_bit;
   assign done            = end_no_presence | end_timeout | end_frame;

   // Checksum: 8-bit sum of all bytes but the last
   always_comb begin
      check_acc = 8'd0;
      for (int unsigned k = 0; k + 1 < FRAME_BYTES; k++) begin
         check_acc = check_acc + frame_byte(frame_ff, k);
      end
   end

   assign check_ok = check_acc == frame_byte(frame_ff, FRAME_BYTES - 1);

   always_comb begin
      if (end_no_presence) begin
         status = ST_NO_PRESENCE;
      end else if (end_timeout) begin
         status = ST_TIMEOUT;
      end else if (end_frame && !check_ok) begin
         status = ST_CHECKSUM;
      end else begin
         status = ST_OK;
      end
   end

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         PH_IDLE:      if (req.start_request) phase_in = PH_START_LOW;
         PH_START_LOW: if (reached) phase_in = PH_PRESENCE;
         PH_PRESENCE:  if (reached) phase_in = req.line_level ? PH_DATA_WAIT : PH_IDLE;
         PH_DATA_WAIT: if (reached) phase_in = PH_WAIT_RISE;
         PH_WAIT_RISE: begin
            if (req.line_level) begin
               phase_in = PH_SAMPLE;
            end else if (reached) begin
               phase_in = PH_IDLE;
            end
         end
         PH_SAMPLE:    if (reached) phase_in = PH_WAIT_FALL;
         PH_WAIT_FALL: begin
            if (!req.line_level) begin
               phase_in = last_bit ? PH_IDLE : PH_WAIT_RISE;
            end else if (reached) begin
               phase_in = PH_IDLE;
            end
         end
         default:      phase_in = PH_IDLE;
      endcase
   end

   // Counter, bit index, frame shift and light latch
   always_comb begin
      tick_cnt_in = tick_cnt_ff;
      bit_idx_in  = bit_idx_ff;
      frame_in    = frame_ff;
      light_in    = light_ff;
      case (phase_ff)
         PH_IDLE: begin
            if (req.start_request) begin
               light_in    = req.light_sample;
               tick_cnt_in = '0;
               bit_idx_in  = '0;
               frame_in    = '0;
            end
         end
         PH_START_LOW, PH_PRESENCE, PH_DATA_WAIT: begin
            tick_cnt_in = reached ? '0 : cnt_step;
         end
         PH_WAIT_RISE: begin
            tick_cnt_in = req.line_level ? '0 : cnt_step;
         end
         PH_SAMPLE: begin
            if (reached) begin
               frame_in    = {frame_ff[FRAME_BITS-2:0], req.line_level};
               tick_cnt_in = '0;
            end else begin
               tick_cnt_in = cnt_step;
            end
         end
         PH_WAIT_FALL: begin
            if (!req.line_level) begin
               tick_cnt_in = '0;
               if (!last_bit) begin
                  bit_idx_in = bit_idx_ff + 1'b1;
               end
            end else begin
               tick_cnt_in = cnt_step;
            end
         end
         default: begin
            tick_cnt_in = tick_cnt_ff;
         end
      endcase
   end

   // Result word
   always_comb begin
      rsp           = '0;
      rsp.drive_low = phase_in == PH_START_LOW;
      rsp.busy_res  = phase_in != PH_IDLE;
      rsp.done_res  = done;
      if (done) begin
         rsp.status = status;
         if (status == ST_OK) begin
            rsp.temperature = frame_byte(frame_ff, 2);
            rsp.humidity    = frame_byte(frame_ff, 0);
            rsp.light_level = light_ff;
            rsp.payload_sum = frame_byte(frame_ff, 2) + frame_byte(frame_ff, 0) + light_ff;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         tick_cnt_ff <= '0;
         bit_idx_ff  <= '0;
      end else if (step_en) begin
         phase_ff    <= phase_in;
         tick_cnt_ff <= tick_cnt_in;
         bit_idx_ff  <= bit_idx_in;
      end
   end

   // Payload state
   always_ff @(posedge clock) begin
      if (step_en) begin
         frame_ff <= frame_in;
         light_ff <= light_in;
      end
   end

   `SWHR_ASSERT_NEXT(a_done_goes_idle, step_en && done, phase_ff == PH_IDLE)
   `SWHR_ASSERT_NEXT(a_idle_holds, step_en && (phase_ff == PH_IDLE) && !req.start_request, phase_ff == PH_IDLE)
   `SWHR_ASSERT_NEXT(a_sample_clears_cnt, step_en && (phase_ff == PH_SAMPLE) && reached, (tick_cnt_ff == '0) && (phase_ff == PH_WAIT_FALL))
   `SWHR_ASSERT_SAME(a_drive_only_start, rsp.drive_low, !done && rsp.busy_res)

endmodule

// ===== test/testbench.sv =====
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import swhr_pkg::*;

   // Register slots past the defined list; writes there must change nothing
   localparam logic [2:0] FIRST_SPARE_REG = 3'd5;
   localparam int unsigned SPARE_REG_COUNT = 3;
   localparam int unsigned MISMATCH_SHOWN = 10;

   typedef enum int unsigned {
      MEAS_GOOD,
      MEAS_BAD_SUM,
      MEAS_NO_PRESENCE,
      MEAS_RISE_TIMEOUT,
      MEAS_FALL_TIMEOUT
   } meas_kind_type;

   // Tracks the sensor sequencer tick by tick and holds the results it owes
   class tick_scoreboard;
      cfg_type cfg;
      phase_type phase;
      logic [COUNTER_WIDTH-1:0] ticks;
      logic [5:0] bit_idx;
      logic [FRAME_BITS-1:0] shift;
      logic presence;
      logic [7:0] light_latch;
      rsp_type expected_q[$];
      int unsigned failures;
      int unsigned checked;
      int unsigned status_seen[4];

      function new();
         cfg.start_low_ticks = START_LOW_RST;
         cfg.presence_delay_ticks = PRESENCE_DLY_RST;
         cfg.data_wait_ticks = DATA_WAIT_RST;
         cfg.sample_delay_ticks = SAMPLE_DLY_RST;
         cfg.bit_timeout_ticks = BIT_TIMEOUT_RST;
         phase = PH_IDLE;
         ticks = '0;
         bit_idx = '0;
         shift = '0;
         presence = 1'b0;
         light_latch = '0;
         failures = 0;
         checked = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
      endfunction

      function void set_reg(input logic [2:0] idx, input logic [31:0] value);
         case (idx)
            REG_START_LOW:    cfg.start_low_ticks = value[15:0];
            REG_PRESENCE_DLY: cfg.presence_delay_ticks = value[9:0];
            REG_DATA_WAIT:    cfg.data_wait_ticks = value[9:0];
            REG_SAMPLE_DLY:   cfg.sample_delay_ticks = value[7:0];
            REG_BIT_TIMEOUT:  cfg.bit_timeout_ticks = value[15:0];
            default: ;
         endcase
      endfunction

      // Advance the saturating tick counter, report whether the limit is hit
      function bit bump(input logic [15:0] limit);
         if (ticks != CNT_MAX) ticks = ticks + 1'b1;
         return ticks >= limit;
      endfunction

      // Byte k of the received frame, byte 0 arrived first
      function logic [7:0] received_byte(input int unsigned k);
         if (k >= FRAME_BYTES) return 8'd0;
         return shift[8 * (FRAME_BYTES - 1 - k) +: 8];
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      function void note_tick(input req_type w);
         rsp_type exp;
         logic done;
         status_type st;
         logic [7:0] acc;
         exp = '0;
         done = 1'b0;
         st = ST_OK;
         case (phase)
            PH_IDLE: begin
               if (w.start_request) begin
                  light_latch = w.light_sample;
                  phase = PH_START_LOW;
                  ticks = '0;
                  bit_idx = '0;
                  shift = '0;
                  presence = 1'b0;
               end
            end
            PH_START_LOW: begin
               if (bump(cfg.start_low_ticks)) begin
                  phase = PH_PRESENCE;
                  ticks = '0;
               end
            end
            PH_PRESENCE: begin
               if (bump(16'(cfg.presence_delay_ticks))) begin
                  presence = w.line_level;
                  ticks = '0;
                  if (w.line_level) begin
                     phase = PH_DATA_WAIT;
                  end else begin
                     done = 1'b1;
                     st = ST_NO_PRESENCE;
                  end
               end
            end
            PH_DATA_WAIT: begin
               if (bump(16'(cfg.data_wait_ticks))) begin
                  phase = PH_WAIT_RISE;
                  ticks = '0;
               end
            end
            PH_WAIT_RISE: begin
               if (w.line_level) begin
                  phase = PH_SAMPLE;
                  ticks = '0;
               end else if (bump(cfg.bit_timeout_ticks)) begin
                  done = 1'b1;
                  st = ST_TIMEOUT;
               end
            end
            PH_SAMPLE: begin
               if (bump(16'(cfg.sample_delay_ticks))) begin
                  shift = {shift[FRAME_BITS-2:0], w.line_level};
                  phase = PH_WAIT_FALL;
                  ticks = '0;
               end
            end
            PH_WAIT_FALL: begin
               if (!w.line_level) begin
                  ticks = '0;
                  if (int'(bit_idx) + 1 >= FRAME_BITS) begin
                     // last bit in: compare the byte sum against the trailing byte
                     acc = '0;
                     for (int k = 0; k < FRAME_BYTES - 1; k++) acc += received_byte(k);
                     done = 1'b1;
                     st = (acc == received_byte(FRAME_BYTES - 1)) ? ST_OK : ST_CHECKSUM;
                  end else begin
                     bit_idx = bit_idx + 1'b1;
                     phase = PH_WAIT_RISE;
                  end
               end else if (bump(cfg.bit_timeout_ticks)) begin
                  done = 1'b1;
                  st = ST_TIMEOUT;
               end
            end
            default: phase = PH_IDLE;
         endcase

         if (done) begin
            phase = PH_IDLE;
            if (st == ST_OK) begin
               exp.temperature = received_byte(2);
               exp.humidity = received_byte(0);
               exp.light_level = light_latch;
               exp.payload_sum = exp.temperature + exp.humidity + exp.light_level;
            end
         end
         exp.drive_low = (phase == PH_START_LOW);
         exp.busy_res = (phase != PH_IDLE);
         exp.done_res = done;
         exp.status = done ? st : ST_OK;
         expected_q.push_back(exp);
      endfunction

      function void check_result(input rsp_type got);
         rsp_type exp;
         if (expected_q.size() == 0) begin
            failures++;
            if (failures <= MISMATCH_SHOWN)
               $display("unexpected result word at %0t: %h", $realtime, got);
            return;
         end
         exp = expected_q.pop_front();
         checked++;
         if (exp.done_res) status_seen[exp.status]++;
         if (got.drive_low !== exp.drive_low || got.busy_res !== exp.busy_res ||
             got.done_res !== exp.done_res || got.status !== exp.status ||
             got.temperature !== exp.temperature || got.humidity !== exp.humidity ||
             got.light_level !== exp.light_level || got.payload_sum !== exp.payload_sum) begin
            failures++;
            if (failures <= MISMATCH_SHOWN) begin
               $display("result %0d mismatch at %0t", checked, $realtime);
               $display("  expected drive=%b busy=%b done=%b st=%0d t=%0d h=%0d l=%0d s=%0d",
                        exp.drive_low, exp.busy_res, exp.done_res, exp.status,
                        exp.temperature, exp.humidity, exp.light_level, exp.payload_sum);
               $display("  actual   drive=%b busy=%b done=%b st=%0d t=%0d h=%0d l=%0d s=%0d",
                        got.drive_low, got.busy_res, got.done_res, got.status,
                        got.temperature, got.humidity, got.light_level, got.payload_sum);
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   tick_scoreboard board;
   int unsigned burst_left = 0;
   int unsigned ticks_sent = 0;
   int unsigned meas_count = 0;
   int unsigned settings_count = 0;
   int unsigned stall_left = 0;
   int unsigned calm_left = 0;

   single_wire_humidity_sensor_reader_top uut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Receiver: check each accepted word, stall in short random bursts
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_result(rsp_data);
      if (stall_left != 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ready <= 1'b1;
         if (calm_left != 0) begin
            calm_left--;
         end else if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 6);
         end else if ($urandom_range(0, 63) == 0) begin
            calm_left = $urandom_range(50, 400);
         end
      end
   end

   function automatic logic rnd_bit();
      return 1'($urandom_range(0, 1));
   endfunction

   // Start requests sprinkled into a running measurement, all to be ignored
   function automatic logic stray_start();
      return $urandom_range(0, 7) == 0;
   endfunction

   function automatic logic [7:0] any_light();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic int unsigned at_least_one(input int unsigned v);
      return (v == 0) ? 1 : v;
   endfunction

   function automatic meas_kind_type pick_kind();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 65) return MEAS_GOOD;
      if (r < 77) return MEAS_BAD_SUM;
      if (r < 85) return MEAS_NO_PRESENCE;
      if (r < 93) return MEAS_RISE_TIMEOUT;
      return MEAS_FALL_TIMEOUT;
   endfunction

   // Send one tick word; the sender runs in bursts, mostly with gaps between them
   task automatic send_tick(input logic start, input logic line, input logic [7:0] light);
      int unsigned gap;
      req_type w;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 400)
                                                   : $urandom_range(1, 40);
      end
      burst_left--;
      w.start_request = start;
      w.line_level = line;
      w.light_sample = light;
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (!req_ready);
      board.note_tick(w);
      ticks_sent++;
   endtask

   task automatic idle_ticks(input int unsigned n);
      repeat (n) send_tick(1'b0, rnd_bit(), any_light());
   endtask

   // Hold the sender until every owed result is back, then let the pipe settle
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      board.set_reg(idx, value);
   endtask

   // Write all timing registers, with junk above each field's width
   task automatic configure(input logic [15:0] start_low, input logic [9:0] presence_dly,
                            input logic [9:0] data_wait, input logic [7:0] sample_dly,
                            input logic [15:0] bit_timeout);
      csr_write(REG_START_LOW, {16'($urandom), start_low});
      csr_write(REG_PRESENCE_DLY, {22'($urandom), presence_dly});
      csr_write(REG_DATA_WAIT, {22'($urandom), data_wait});
      csr_write(REG_SAMPLE_DLY, {24'($urandom), sample_dly});
      csr_write(REG_BIT_TIMEOUT, {16'($urandom), bit_timeout});
      settings_count++;
   endtask

   // Start a measurement, run n ticks of its start pulse, then drain
   task automatic start_partial(input int unsigned n);
      send_tick(1'b1, rnd_bit(), any_light());
      repeat (n) send_tick(stray_start(), rnd_bit(), any_light());
      wait_drained();
   endtask

   // Hold the line low until the sequencer drops back to idle
   task automatic finish_with_low_line();
      while (board.phase != PH_IDLE) send_tick(1'b0, 1'b0, any_light());
   endtask

   // Play the sensor's side of one measurement, broken where kind asks
   task automatic run_measurement(input meas_kind_type kind, input logic [7:0] light,
                                  input logic [31:0] bytes, input int unsigned slack,
                                  input int unsigned fail_at);
      int unsigned start_n, pres_n, wait_n, samp_n, tmo_n, room, lead;
      logic [7:0] check;
      logic [FRAME_BITS-1:0] frame;
      start_n = at_least_one(board.cfg.start_low_ticks);
      pres_n = at_least_one(board.cfg.presence_delay_ticks);
      wait_n = at_least_one(board.cfg.data_wait_ticks);
      samp_n = at_least_one(board.cfg.sample_delay_ticks);
      tmo_n = at_least_one(board.cfg.bit_timeout_ticks);
      room = (tmo_n - 1 < slack) ? tmo_n - 1 : slack;
      check = bytes[31:24] + bytes[23:16] + bytes[15:8] + bytes[7:0];
      if (kind == MEAS_BAD_SUM) check ^= 8'($urandom_range(1, 255));
      frame = {bytes, check};
      meas_count++;

      // start pulse and presence window
      send_tick(1'b1, rnd_bit(), light);
      repeat (start_n) send_tick(stray_start(), rnd_bit(), any_light());
      repeat (pres_n - 1) send_tick(stray_start(), rnd_bit(), any_light());
      if (kind == MEAS_NO_PRESENCE) begin
         send_tick(rnd_bit(), 1'b0, any_light());
         return;
      end
      send_tick(stray_start(), 1'b1, any_light());
      repeat (wait_n) send_tick(stray_start(), rnd_bit(), any_light());

      // data bits, most significant first
      for (int i = 0; i < FRAME_BITS; i++) begin
         if (kind == MEAS_RISE_TIMEOUT && i == fail_at) begin
            repeat (tmo_n - 1) send_tick(stray_start(), 1'b0, any_light());
            send_tick(rnd_bit(), 1'b0, any_light());
            return;
         end
         lead = $urandom_range(0, room);
         repeat (lead) send_tick(stray_start(), 1'b0, any_light());
         send_tick(stray_start(), 1'b1, any_light());
         repeat (samp_n - 1) send_tick(stray_start(), rnd_bit(), any_light());
         send_tick(stray_start(), frame[FRAME_BITS-1-i], any_light());
         if (kind == MEAS_FALL_TIMEOUT && i == fail_at) begin
            repeat (tmo_n - 1) send_tick(stray_start(), 1'b1, any_light());
            send_tick(rnd_bit(), 1'b1, any_light());
            return;
         end
         lead = $urandom_range(0, room);
         repeat (lead) send_tick(stray_start(), 1'b1, any_light());
         send_tick((i == FRAME_BITS - 1) ? rnd_bit() : stray_start(), 1'b0, any_light());
      end
   endtask

   initial begin
      board = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset timings: the start pulse is long, so stop partway through it
      start_partial(24);

      // shortest timings end the pulse; then every ending, spare slots written
      configure(16'd1, 10'd1, 10'd1, 8'd1, 16'd1);
      for (int k = 0; k < SPARE_REG_COUNT; k++) csr_write(FIRST_SPARE_REG + 3'(k), $urandom);
      finish_with_low_line();
      run_measurement(MEAS_GOOD, 8'hFF, 32'hFFFF_FFFF, 0, 0);
      run_measurement(MEAS_BAD_SUM, any_light(), $urandom, 0, 0);
      run_measurement(MEAS_NO_PRESENCE, any_light(), $urandom, 0, 0);
      run_measurement(MEAS_RISE_TIMEOUT, any_light(), $urandom, 0, 0);
      run_measurement(MEAS_FALL_TIMEOUT, any_light(), $urandom, 0, 2);
      idle_ticks(3);
      wait_drained();

      // zero in every register acts as one
      configure(16'd0, 10'd0, 10'd0, 8'd0, 16'd0);
      run_measurement(MEAS_RISE_TIMEOUT, any_light(), $urandom, 0, 5);
      run_measurement(MEAS_FALL_TIMEOUT, any_light(), $urandom, 0, 1);
      run_measurement(MEAS_NO_PRESENCE, any_light(), $urandom, 0, 0);
      wait_drained();

      // full-width timings, cut short by the shortest ones
      configure(16'hFFFF, 10'h3FF, 10'h3FF, 8'hFF, 16'hFFFF);
      start_partial(20);
      configure(16'd1, 10'd1, 10'd1, 8'd1, 16'd1);
      finish_with_low_line();
      wait_drained();

      // random short timings, random ending
      configure(16'($urandom_range(0, 3)), 10'($urandom_range(0, 3)),
                10'($urandom_range(0, 3)), 8'($urandom_range(0, 2)),
                16'($urandom_range(1, 4)));
      run_measurement(pick_kind(), any_light(), $urandom, $urandom_range(0, 1),
                      $urandom_range(0, FRAME_BITS - 1));
      idle_ticks($urandom_range(0, 4));
      wait_drained();

      repeat (8) @(posedge clock);
      $display("Covered %0d tick words, %0d measurements over %0d register settings",
               ticks_sent, meas_count, settings_count + 1);
      $display("Endings: ok %0d, checksum %0d, no presence %0d, timeout %0d; failures %0d",
               board.status_seen[ST_OK], board.status_seen[ST_CHECKSUM],
               board.status_seen[ST_NO_PRESENCE], board.status_seen[ST_TIMEOUT],
               board.failures);
      if (board.failures == 0 && board.pending() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Watchdog: drop the run if it hangs
   initial begin
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end
endmodule
